// ===== sv/esd_pkg.sv =====
// shared types and character constants for the escape sequence decoder
package esd_pkg;

   localparam int MAX_RESULTS       = 4;
   localparam int COUNT_WIDTH       = $clog2(MAX_RESULTS + 1);
   localparam int OCTAL_MAX_DIGITS  = 3;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_ONE       = 8'h31;
   localparam logic [7:0] CHAR_SEVEN     = 8'h37;
   localparam logic [7:0] CODE_BACKSPACE = 8'h08;
   localparam logic [7:0] CODE_TAB       = 8'h09;
   localparam logic [7:0] CODE_CR        = 8'h0D;
   localparam logic [7:0] CODE_LF        = 8'h0A;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_OCTAL  = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type    parse_mode;
      logic [1:0]  octal_digits;
      logic [6:0]  octal_value;
      logic [7:0]  held_byte;
      logic        held_valid;
      logic        at_text_start;
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_end;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] entry;
      logic [COUNT_WIDTH-1:0]       count;
   } result_set_type;

endpackage

// ===== sv/esd_decode.sv =====
// combinational decode of one raw byte into up to four results and the next state
module esd_decode (
   input  esd_pkg::state_type      state_now,
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   input  logic                    quoted_mode,
   output esd_pkg::state_type      state_next,
   output esd_pkg::result_set_type results
);

   typedef struct packed {
      esd_pkg::state_type      st;
      esd_pkg::result_set_type rs;
   } work_type;

   function automatic work_type put_result(work_type w, logic [7:0] b, logic e);
      work_type r;
      r = w;
      if (r.rs.count < esd_pkg::COUNT_WIDTH'(esd_pkg::MAX_RESULTS)) begin
         r.rs.entry[r.rs.count[$clog2(esd_pkg::MAX_RESULTS)-1:0]] = '{out_byte: b, is_end: e};
         r.rs.count = r.rs.count + 1'b1;
      end
      return r;
   endfunction

   function automatic work_type give_decoded(work_type w, logic [7:0] b, logic q);
      work_type r;
      r = w;
      if (q) begin
         if (r.st.held_valid) r = put_result(r, r.st.held_byte, 1'b0);
         r.st.held_byte  = b;
         r.st.held_valid = 1'b1;
      end else begin
         if (r.st.held_valid) begin
            r = put_result(r, r.st.held_byte, 1'b0);
            r.st.held_valid = 1'b0;
            r.st.held_byte  = '0;
         end
         r = put_result(r, b, 1'b0);
      end
      return r;
   endfunction

   work_type w;
   logic     skip_byte;
   logic     absorbed;
   logic     is_octal;

   always_comb begin
      w          = '0;
      w.st       = state_now;
      skip_byte  = state_now.at_text_start && quoted_mode;
      absorbed   = 1'b0;
      is_octal   = (in_byte >= esd_pkg::CHAR_ZERO) && (in_byte <= esd_pkg::CHAR_SEVEN);
      w.st.at_text_start = 1'b0;

      if (!skip_byte) begin
         // an open octal escape takes the digit or is flushed
         if (w.st.parse_mode == esd_pkg::MODE_OCTAL) begin
            if (is_octal && (w.st.octal_digits < 2'(esd_pkg::OCTAL_MAX_DIGITS))) begin
               w.st.octal_value  = {w.st.octal_value[3:0], in_byte[2:0]};
               w.st.octal_digits = w.st.octal_digits + 1'b1;
               absorbed = 1'b1;
            end else begin
               w = give_decoded(w, {1'b0, w.st.octal_value}, quoted_mode);
               w.st.parse_mode   = esd_pkg::MODE_NORMAL;
               w.st.octal_digits = '0;
               w.st.octal_value  = '0;
            end
         end
         if (!absorbed) begin
            case (w.st.parse_mode)
               esd_pkg::MODE_ESCAPE: begin
                  w.st.parse_mode = esd_pkg::MODE_NORMAL;
                  case (in_byte)
                     esd_pkg::CHAR_LOWER_B: w = give_decoded(w, esd_pkg::CODE_BACKSPACE, quoted_mode);
                     esd_pkg::CHAR_LOWER_T: w = give_decoded(w, esd_pkg::CODE_TAB, quoted_mode);
                     esd_pkg::CHAR_LOWER_R: w = give_decoded(w, esd_pkg::CODE_CR, quoted_mode);
                     esd_pkg::CHAR_LOWER_N: w = give_decoded(w, esd_pkg::CODE_LF, quoted_mode);
                     esd_pkg::CHAR_ZERO, esd_pkg::CHAR_ONE: begin
                        w.st.parse_mode   = esd_pkg::MODE_OCTAL;
                        w.st.octal_digits = 2'd1;
                        w.st.octal_value  = {6'd0, in_byte[0]};
                     end
                     default: w = give_decoded(w, in_byte, quoted_mode);
                  endcase
               end
               default: begin
                  w.st.parse_mode = esd_pkg::MODE_NORMAL;
                  if (in_byte == esd_pkg::CHAR_BACKSLASH) w.st.parse_mode = esd_pkg::MODE_ESCAPE;
                  else w = give_decoded(w, in_byte, quoted_mode);
               end
            endcase
         end
      end

      // end of text: flush octal, drop held byte, add terminator
      if (in_last) begin
         if (w.st.parse_mode == esd_pkg::MODE_OCTAL)
            w = give_decoded(w, {1'b0, w.st.octal_value}, quoted_mode);
         w.st.parse_mode    = esd_pkg::MODE_NORMAL;
         w.st.octal_digits  = '0;
         w.st.octal_value   = '0;
         w.st.held_byte     = '0;
         w.st.held_valid    = 1'b0;
         w.st.at_text_start = 1'b1;
         w = put_result(w, 8'd0, 1'b1);
      end

      state_next = w.st;
      results    = w.rs;
   end

endmodule

// ===== sv/esd_rsp_queue.sv =====
// result buffer that loads up to four results at once and drains one per cycle while rsp_tready is high
module esd_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  esd_pkg::result_set_type load_set,
   output logic                    can_load,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output esd_pkg::result_type     rsp_head
);

   esd_pkg::result_type [esd_pkg::MAX_RESULTS-1:0] entry_ff, entry_in;
   logic [esd_pkg::COUNT_WIDTH-1:0]                left_ff, left_in;
   logic                                           pop;

   assign rsp_tvalid = (left_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign can_load   = (left_ff == '0) ||
                       ((left_ff == esd_pkg::COUNT_WIDTH'(1)) && rsp_tready);
   assign rsp_head   = entry_ff[0];

   always_comb begin
      entry_in = entry_ff;
      left_in  = left_ff;
      if (load) begin
         entry_in = load_set.entry;
         left_in  = load_set.count;
      end else if (pop) begin
         for (int i = 0; i < esd_pkg::MAX_RESULTS - 1; i++) entry_in[i] = entry_ff[i+1];
         left_in = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) left_ff <= '0;
      else left_ff <= left_in;
   end

endmodule

// ===== sv/escape_sequence_decoder.sv =====
// top level of the escape sequence decoder: input register, decode, result buffer
// an accepted transaction is registered, decoded, then loaded into the result buffer
// throughput: one input transaction per cycle while each yields at most one result
//   and rsp_tready is high; an input with more results (up to four) holds the buffer
// reset: synchronous, active high; clears control state, quoted mode and the
//   parser state (normal mode, start of text, nothing held)
module escape_sequence_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,     // quoted_mode
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // in_byte[7:0]
   input  logic       req_tlast,     // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // out_byte[7:0]
   output logic       rsp_tlast      // is_end
);

   // configuration register
   logic quoted_ff, quoted_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   // parser state
   esd_pkg::state_type state_ff, state_in, state_next;

   esd_pkg::result_set_type results;
   esd_pkg::result_type     rsp_head;
   logic                    can_load;
   logic                    advance;
   logic                    req_take;

   // an input is decoded once the result buffer is free or freeing this cycle
   assign advance    = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      quoted_in   = csr_we ? csr_wdata : quoted_ff;
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in  = req_take ? req_tdata : in_byte_ff;
      in_last_in  = req_take ? req_tlast : in_last_ff;
      state_in    = advance ? state_next : state_ff;
   end

   esd_decode u_decode (
      .state_now   (state_ff),
      .in_byte     (in_byte_ff),
      .in_last     (in_last_ff),
      .quoted_mode (quoted_ff),
      .state_next  (state_next),
      .results     (results)
   );

   esd_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_set   (results),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_head   (rsp_head)
   );

   assign rsp_tdata = rsp_head.out_byte;
   assign rsp_tlast = rsp_head.is_end;

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      if (reset) begin
         quoted_ff   <= 1'b0;
         in_valid_ff <= 1'b0;
         state_ff    <= '{parse_mode:    esd_pkg::MODE_NORMAL,
                          octal_digits:  2'd0,
                          octal_value:   7'd0,
                          held_byte:     8'd0,
                          held_valid:    1'b0,
                          at_text_start: 1'b1};
      end else begin
         quoted_ff   <= quoted_in;
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

endmodule
